// ===== src/tbs_pkg.sv =====
// ----------------------------------------------------------------------------
// tbs_pkg: shared types and constants of the bilinear texture sampler
// Widths, command and register codes, item structs and the state machine
// types used by the sampler's modules.
// ----------------------------------------------------------------------------
package tbs_pkg;

	// Block dimensions
	localparam int MAX_WIDTH       = 256;
	localparam int MAX_HEIGHT      = 256;
	localparam int COORD_FRAC_BITS = 16;

	localparam int COORD_W  = 24;
	localparam int DIM_W    = 9;
	localparam int ADDR_W   = 16;
	localparam int CH_W     = 8;
	localparam int RES_W    = 16;
	localparam int NUM_CH   = 3;
	localparam int FRAC_W   = COORD_FRAC_BITS;
	localparam int CFG_IDX_W = 1;

	localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int AX_W    = ($clog2(MAX_DIM) < 1) ? 1 : $clog2(MAX_DIM);

	// Scaled coordinate, its integer part and the offset dividend
	localparam int PROD_W = COORD_W + DIM_W;
	localparam int BASE_W = PROD_W - FRAC_W;
	localparam int DIV_W  = BASE_W + DIM_W - 1;
	localparam int CNT_W  = $clog2(DIV_W);

	// Blend arithmetic
	localparam int WGT_W   = FRAC_W + 1;
	localparam int WPROD_W = 2 * WGT_W;
	localparam int ACC_W   = WPROD_W + CH_W;
	localparam int RES_LSB = 2 * FRAC_W - 8;
	localparam int ROW_W   = AX_W + DIM_W;

	localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1) << FRAC_W;

	// Commands
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 1'd1;

	localparam logic [DIM_W-1:0] TEX_DIM_RESET = 9'd256;

	typedef struct packed {
		logic                      cmd;
		logic [ADDR_W-1:0]         texel_index;
		logic [CH_W-1:0]           texel_red;
		logic [CH_W-1:0]           texel_green;
		logic [CH_W-1:0]           texel_blue;
		logic signed [COORD_W-1:0] coord_u;
		logic signed [COORD_W-1:0] coord_v;
	} req_item_t;

	typedef struct packed {
		logic [RES_W-1:0] out_red;
		logic [RES_W-1:0] out_green;
		logic [RES_W-1:0] out_blue;
	} rsp_item_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} texel_t;

	// Result of one axis pass
	typedef struct packed {
		logic              done;
		logic [AX_W-1:0]   ra;
		logic [AX_W-1:0]   rb;
		logic [FRAC_W-1:0] frac;
	} ax_res_t;

	typedef struct packed {
		logic clear;
		logic valid;
	} blend_ctl_t;

	typedef enum logic [1:0] {
		AX_IDLE,
		AX_MUL,
		AX_DIV,
		AX_DONE
	} ax_state_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AXIS_U,
		ST_AXIS_V,
		ST_ROW,
		ST_READ,
		ST_DRAIN
	} sm_state_t;

	// Zero counts as one, anything above the maximum as the maximum.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d,
		input logic [DIM_W-1:0] maxd);
		logic [DIM_W-1:0] r;
		if (d == '0) begin
			r = DIM_W'(1);
		end else if (d > maxd) begin
			r = maxd;
		end else begin
			r = d;
		end
		return r;
	endfunction

endpackage

// ===== src/tbs_axis.sv =====
// ----------------------------------------------------------------------------
// tbs_axis: shared scale, floor and wrap unit
// Scales one coordinate by a dimension, splits off the fraction and takes the
// positive remainder of the integer part by restoring division, one bit a
// cycle.
// ----------------------------------------------------------------------------
module tbs_axis
	import tbs_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [COORD_W-1:0] coord,
	input  logic [DIM_W-1:0]          dim,
	output ax_res_t                   res
);

	ax_state_t state_q, state_d;

	logic signed [PROD_W-1:0] prod_d;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [DIM_W:0]    dim_s;
	logic [DIM_W-1:0]         dim_q;
	logic [DIV_W-1:0]         div_q;
	logic [DIV_W-1:0]         div_d;
	logic [DIM_W-1:0]         rem_q;
	logic [DIM_W-1:0]         rem_d;
	logic [DIM_W:0]           trial;
	logic [DIM_W:0]           rem_p1;
	logic [FRAC_W-1:0]        frac_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [BASE_W-1:0]        base;

	assign dim_s  = {1'b0, dim};
	assign prod_d = coord * dim_s;

	// The floor of the scaled value is an arithmetic shift; adding dim times a
	// large power of two keeps the dividend positive without moving the residue.
	assign base  = prod_q[PROD_W-1:FRAC_W];
	assign div_d = {{(DIV_W-BASE_W){base[BASE_W-1]}}, base} +
		(DIV_W'(dim_q) << (BASE_W - 1));

	assign trial = {rem_q, div_q[DIV_W-1]};
	assign rem_d = (trial >= {1'b0, dim_q}) ? DIM_W'(trial - {1'b0, dim_q})
		: trial[DIM_W-1:0];

	assign rem_p1 = {1'b0, rem_q} + (DIM_W+1)'(1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			AX_IDLE: begin
				if (start) begin
					state_d = AX_MUL;
				end
			end
			AX_MUL: begin
				state_d = AX_DIV;
			end
			AX_DIV: begin
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					state_d = AX_DONE;
				end
			end
			AX_DONE: begin
				state_d = start ? AX_MUL : AX_IDLE;
			end
			default: begin
				state_d = AX_IDLE;
			end
		endcase
	end

	always_comb begin
		res.done = (state_q == AX_DONE);
		res.ra   = rem_q[AX_W-1:0];
		res.rb   = (rem_p1 == {1'b0, dim_q}) ? '0 : rem_p1[AX_W-1:0];
		res.frac = frac_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= AX_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == AX_MUL) begin
				cnt_q <= '0;
			end else if (state_q == AX_DIV) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_q <= prod_d;
			dim_q  <= dim;
		end
		if (state_q == AX_MUL) begin
			div_q  <= div_d;
			rem_q  <= '0;
			frac_q <= prod_q[FRAC_W-1:0];
		end else if (state_q == AX_DIV) begin
			div_q <= div_q << 1;
			rem_q <= rem_d;
		end
	end

endmodule

// ===== src/tbs_store.sv =====
// ----------------------------------------------------------------------------
// tbs_store: texel memory
// Single-ported RGB888 store with one address, write and registered read.
// ----------------------------------------------------------------------------
module tbs_store
	import tbs_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  texel_t            wdata,
	output texel_t            rdata
);

	localparam int DEPTH = 1 << ADDR_W;

	texel_t mem_q [DEPTH];
	texel_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/tbs_blend.sv =====
// ----------------------------------------------------------------------------
// tbs_blend: bilinear weight and accumulate lanes
// Forms each texel's weight, multiplies it into the three color lanes and
// accumulates the four corners of a sample.
// ----------------------------------------------------------------------------
module tbs_blend
	import tbs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  blend_ctl_t       ctl,
	input  texel_t           texel,
	input  logic [WGT_W-1:0] wx,
	input  logic [WGT_W-1:0] wy,
	output logic             busy,
	output rsp_item_t        result
);

	logic                v_s1;
	logic                v_s2;
	logic [WPROD_W-1:0]  wgt_d;
	logic [WPROD_W-1:0]  wgt_s1;
	logic [CH_W-1:0]     col_in [NUM_CH];
	logic [CH_W-1:0]     col_s1 [NUM_CH];
	logic [ACC_W-1:0]    prod_d [NUM_CH];
	logic [ACC_W-1:0]    prod_s2 [NUM_CH];
	logic [ACC_W-1:0]    acc_q [NUM_CH];

	assign wgt_d     = wx * wy;
	assign col_in[0] = texel.red;
	assign col_in[1] = texel.green;
	assign col_in[2] = texel.blue;

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			prod_d[c] = col_s1[c] * wgt_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ctl.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		wgt_s1 <= wgt_d;
		for (int c = 0; c < NUM_CH; c++) begin
			col_s1[c]  <= col_in[c];
			prod_s2[c] <= prod_d[c];
			if (ctl.clear) begin
				acc_q[c] <= '0;
			end else if (v_s2) begin
				acc_q[c] <= acc_q[c] + prod_s2[c];
			end
		end
	end

	assign busy             = v_s1 | v_s2;
	assign result.out_red   = acc_q[0][RES_LSB +: RES_W];
	assign result.out_green = acc_q[1][RES_LSB +: RES_W];
	assign result.out_blue  = acc_q[2][RES_LSB +: RES_W];

endmodule

// ===== src/texture_bilinear_sampler.sv =====
// A sample runs two 25-step remainder passes of the shared axis unit (u, then v),
// the row offsets, the corner reads and the blend drain before its result is
// registered, later only while a stalled consumer holds the result register; no
// new request is taken till then. Texel loads are taken one per cycle while idle.
// Reset: arst_n clears the sequencer, handshakes and both size registers
// (to 256); the texel memory is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
// texture_bilinear_sampler: bilinear texture filter with wrap addressing
// Keeps an RGB888 texel memory, and turns signed Q8.16 coordinates into a
// bilinear blend of four wrapped texels, given per channel as Q8.8 bytes.
// ----------------------------------------------------------------------------
module texture_bilinear_sampler
	import tbs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	// Configuration write port
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_wdata,

	// Request channel: texel loads and sample requests
	input  logic                 req_valid,
	output logic                 req_ready,
	input  req_item_t            req,

	// Response channel: one blended color per sample
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rsp_item_t            rsp
);

	sm_state_t state_q, state_d;

	// Configuration and the sizes actually used
	logic [DIM_W-1:0] tex_width_q;
	logic [DIM_W-1:0] tex_height_q;
	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;

	// Axis unit
	logic                      ax_start;
	logic signed [COORD_W-1:0] ax_coord;
	logic [DIM_W-1:0]          ax_dim;
	ax_res_t                   ax_res;
	logic signed [COORD_W-1:0] coord_v_q;

	// Wrapped positions and fractions of the current sample
	logic [AX_W-1:0]   xa_q;
	logic [AX_W-1:0]   xb_q;
	logic [AX_W-1:0]   ya_q;
	logic [AX_W-1:0]   yb_q;
	logic [FRAC_W-1:0] fx_q;
	logic [FRAC_W-1:0] fy_q;
	logic [ROW_W-1:0]  rowa_d;
	logic [ROW_W-1:0]  rowb_d;
	logic [ADDR_W-1:0] rowa_q;
	logic [ADDR_W-1:0] rowb_q;

	// Texel reads
	logic [1:0]        rd_k_q;
	logic [1:0]        rd_kd_q;
	logic              rd_v_q;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] mem_addr;
	logic              mem_we;
	texel_t            mem_wdata;
	texel_t            mem_rdata;

	// Blend lanes
	blend_ctl_t        blend_ctl;
	logic [WGT_W-1:0]  wx;
	logic [WGT_W-1:0]  wy;
	logic              blend_busy;
	rsp_item_t         blend_res;
	logic              pending;

	// Output register
	logic              rsp_valid_q;
	rsp_item_t         rsp_q;
	logic              rsp_load;
	logic              slot_free;

	// ------------------------------------------------------------------
	// Configuration. Sizes are clamped on use: zero reads as one and values
	// above the maximum read as the maximum.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q  <= TEX_DIM_RESET;
			tex_height_q <= TEX_DIM_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_TEX_WIDTH:  tex_width_q  <= cfg_wdata;
				REG_TEX_HEIGHT: tex_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign w_eff = clamp_dim(tex_width_q, DIM_W'(MAX_WIDTH));
	assign h_eff = clamp_dim(tex_height_q, DIM_W'(MAX_HEIGHT));

	// ------------------------------------------------------------------
	// Sequencer. A sample runs u through the axis unit, then v, forms the
	// two row offsets, reads the four corners one per cycle, and waits for the
	// blend lanes to drain and the output register to be free to take the result.
	// ------------------------------------------------------------------
	assign pending   = rd_v_q | blend_busy;
	assign slot_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid && req.cmd == CMD_SAMPLE) begin
					state_d = ST_AXIS_U;
				end
			end
			ST_AXIS_U: begin
				if (ax_res.done) begin
					state_d = ST_AXIS_V;
				end
			end
			ST_AXIS_V: begin
				if (ax_res.done) begin
					state_d = ST_ROW;
				end
			end
			ST_ROW: begin
				state_d = ST_READ;
			end
			ST_READ: begin
				if (rd_k_q == 2'd3) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!pending && slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready       = (state_q == ST_IDLE);
		ax_start        = ((state_q == ST_IDLE) && req_valid && req.cmd == CMD_SAMPLE) ||
			((state_q == ST_AXIS_U) && ax_res.done);
		ax_coord        = (state_q == ST_IDLE) ? req.coord_u : coord_v_q;
		ax_dim          = (state_q == ST_IDLE) ? w_eff : h_eff;
		mem_we          = (state_q == ST_IDLE) && req_valid && req.cmd == CMD_LOAD;
		mem_addr        = (state_q == ST_IDLE) ? req.texel_index : rd_addr;
		blend_ctl.clear = (state_q == ST_IDLE);
		blend_ctl.valid = rd_v_q;
		rsp_load        = (state_q == ST_DRAIN) && !pending && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_k_q      <= '0;
			rd_v_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_q  <= (state_q == ST_READ);
			if (state_q == ST_ROW) begin
				rd_k_q <= '0;
			end else if (state_q == ST_READ) begin
				rd_k_q <= rd_k_q + 2'd1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Sample payload registers
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			coord_v_q <= req.coord_v;
		end
		if (state_q == ST_AXIS_U && ax_res.done) begin
			xa_q <= ax_res.ra;
			xb_q <= ax_res.rb;
			fx_q <= ax_res.frac;
		end
		if (state_q == ST_AXIS_V && ax_res.done) begin
			ya_q <= ax_res.ra;
			yb_q <= ax_res.rb;
			fy_q <= ax_res.frac;
		end
		if (state_q == ST_ROW) begin
			rowa_q <= rowa_d[ADDR_W-1:0];
			rowb_q <= rowb_d[ADDR_W-1:0];
		end
		rd_kd_q <= rd_k_q;
		if (rsp_load) begin
			rsp_q <= blend_res;
		end
	end

	// Row offsets wrap at the memory depth, as the address does.
	assign rowa_d = ya_q * w_eff;
	assign rowb_d = yb_q * w_eff;

	// Corner order: bit 0 picks the right column, bit 1 the lower row.
	assign rd_addr = (rd_k_q[1] ? rowb_q : rowa_q) + ADDR_W'(rd_k_q[0] ? xb_q : xa_q);

	// Weights follow the corner whose data is arriving from the memory.
	assign wx = rd_kd_q[0] ? {1'b0, fx_q} : WGT_ONE - {1'b0, fx_q};
	assign wy = rd_kd_q[1] ? {1'b0, fy_q} : WGT_ONE - {1'b0, fy_q};

	assign mem_wdata.red   = req.texel_red;
	assign mem_wdata.green = req.texel_green;
	assign mem_wdata.blue  = req.texel_blue;

	tbs_axis u_axis (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ax_start),
		.coord  (ax_coord),
		.dim    (ax_dim),
		.res    (ax_res)
	);

	tbs_store u_store (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	tbs_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (blend_ctl),
		.texel  (mem_rdata),
		.wx     (wx),
		.wy     (wy),
		.busy   (blend_busy),
		.result (blend_res)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
`ifndef SYNTHESIS
	// No read or blend work is left over once a new request can be taken.
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !pending)
		else $error("blend work pending while the sampler is idle");

	// The axis unit finishes only while the sequencer waits for it.
	a_axis_expected: assert property (@(posedge clk) disable iff (!arst_n)
		ax_res.done |-> (state_q == ST_AXIS_U || state_q == ST_AXIS_V))
		else $error("axis result arrived outside an axis pass");

	// Wrapped column positions stay inside the texture width.
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_AXIS_U && ax_res.done) |->
			(DIM_W'(ax_res.ra) < w_eff && DIM_W'(ax_res.rb) < w_eff))
		else $error("wrapped column outside the texture width");
`endif

endmodule
